@@ src/day_number_to_date_macros.svh @@
// Assertion macros for the day number to date converter.
// Used by the top level; expects i_clk and i_rst_n in the including scope.
`ifndef DAY_NUMBER_TO_DATE_MACROS_SVH
`define DAY_NUMBER_TO_DATE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DND_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("day_number_to_date: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define DND_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("day_number_to_date: next-cycle check failed");

`endif

@@ src/dnd_pkg.sv @@
// Shared types and constants for the day number to date converter.
// No dependencies; used by dnd_ctrl, dnd_datapath and day_number_to_date.
package dnd_pkg;

    localparam int DAY_NUM_W  = 17;
    localparam int YEAR_OUT_W = 12;
    localparam int MONTH_W    = 4;
    localparam int DAY_W      = 5;
    localparam int YLEN_W     = 14;
    localparam int MOD100_W   = 7;
    localparam int MOD400_W   = 9;

    localparam int unsigned DAYS_PER_YEAR = 365;
    localparam int unsigned FEB_DAYS      = 28;
    localparam int unsigned CENTURY       = 100;
    localparam int unsigned QUAD_CENTURY  = 400;
    localparam int unsigned COARSE_YEARS  = 32;
    localparam int unsigned MID_YEARS     = 4;

    // Days in a run of years with every fourth year leap and no skipped century.
    localparam int unsigned COARSE_DAYS = COARSE_YEARS * DAYS_PER_YEAR + COARSE_YEARS / 4;
    localparam int unsigned MID_DAYS    = MID_YEARS * DAYS_PER_YEAR + MID_YEARS / 4;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_DEC_LAST = 5'd31;

    typedef enum logic [2:0] {
        S_IDLE,
        S_YEAR32,
        S_YEAR4,
        S_YEAR1,
        S_MONTH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic step32;
        logic step4;
        logic step1;
        logic step_month;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic in_range;
        logic fits32;
        logic fits4;
        logic fits1;
        logic fits_month;
    } t_status;

    function automatic logic [DAY_W-1:0] f_month_days(input logic [MONTH_W-1:0] month,
                                                      input logic leap);
        logic [DAY_W-1:0] days;
        case (month)
            MONTH_FEB: days = DAY_W'(FEB_DAYS) + {4'b0, leap};
            4'd4, 4'd6, 4'd9, 4'd11: days = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 5'd31;
            default: days = 5'd0;
        endcase
        return days;
    endfunction

endpackage

@@ src/dnd_ctrl.sv @@
// Controller for the day number to date converter: sequences the year and
// month walks and owns the result valid flag. Depends on dnd_pkg.
module dnd_ctrl
    import dnd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.in_range ? S_YEAR32 : S_DONE;
                end
            end
            S_YEAR32: begin
                if (i_status.fits32) begin
                    o_cmd.step32 = 1'b1;
                end else begin
                    n_state = S_YEAR4;
                end
            end
            S_YEAR4: begin
                if (i_status.fits4) begin
                    o_cmd.step4 = 1'b1;
                end else begin
                    n_state = S_YEAR1;
                end
            end
            S_YEAR1: begin
                if (i_status.fits1) begin
                    o_cmd.step1 = 1'b1;
                end else begin
                    n_state = S_MONTH;
                end
            end
            S_MONTH: begin
                if (i_status.fits_month) begin
                    o_cmd.step_month = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // The output register is free once its beat is taken.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ src/dnd_datapath.sv @@
// Datapath for the day number to date converter: remainder, year, month and
// leap tracking registers plus the output register. Depends on dnd_pkg.
module dnd_datapath
    import dnd_pkg::*;
#(
    parameter int FIRST_YEAR = 1900,
    parameter int LAST_YEAR  = 2099
) (
    input  logic                  i_clk,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic [DAY_NUM_W-1:0]  i_day_number,
    output logic [YEAR_OUT_W-1:0] o_year_out,
    output logic [MONTH_W-1:0]    o_month_out,
    output logic [DAY_W-1:0]      o_day_out,
    output logic                  o_clamped
);

    localparam int LAST_EFF   = (LAST_YEAR < FIRST_YEAR) ? FIRST_YEAR : LAST_YEAR;
    localparam int PRE_YEAR   = FIRST_YEAR - 1;
    localparam int LEAPS_LAST = LAST_EFF / 4 - LAST_EFF / 100 + LAST_EFF / 400;
    localparam int LEAPS_PRE  = PRE_YEAR / 4 - PRE_YEAR / 100 + PRE_YEAR / 400;
    localparam int SPAN       = 365 * (LAST_EFF - FIRST_YEAR + 1) + LEAPS_LAST - LEAPS_PRE;
    localparam int YW         = $clog2(LAST_EFF + 1);
    localparam int STEP_W     = 6;

    localparam logic [31:0]         SPAN_V    = 32'(SPAN);
    localparam logic [YW-1:0]       FIRST_V   = YW'(FIRST_YEAR);
    localparam logic [YW-1:0]       LAST_V    = YW'(LAST_EFF);
    localparam logic [MOD100_W-1:0] M100_INIT = MOD100_W'(FIRST_YEAR % 100);
    localparam logic [MOD400_W-1:0] M400_INIT = MOD400_W'(FIRST_YEAR % 400);

    logic [DAY_NUM_W-1:0]  r_rem,   n_rem;
    logic [YW-1:0]         r_year,  n_year;
    logic [MONTH_W-1:0]    r_month, n_month;
    logic [MOD100_W-1:0]   r_m100,  n_m100;
    logic [MOD400_W-1:0]   r_m400,  n_m400;
    logic                  r_clamp, n_clamp;

    logic [YEAR_OUT_W-1:0] r_out_year;
    logic [MONTH_W-1:0]    r_out_month;
    logic [DAY_W-1:0]      r_out_day;
    logic                  r_out_clamp;

    logic                  leap;
    logic [YLEN_W-1:0]     len1, len4, len32, step_len;
    logic [MOD100_W-1:0]   cen_off;
    logic [MOD400_W:0]     cen_sum, cen_mod;
    logic                  cen_skip;
    logic [DAY_W-1:0]      mdays;
    logic [STEP_W-1:0]     step_years;
    logic [MOD100_W:0]     m100_sum;
    logic [MOD400_W:0]     m400_sum;
    logic [31:0]           day_ext;
    logic                  is_zero, is_high;

    assign leap = ((r_m400[1:0] == 2'd0) && (r_m100 != '0)) || (r_m400 == '0);
    assign len1 = leap ? YLEN_W'(DAYS_PER_YEAR + 1) : YLEN_W'(DAYS_PER_YEAR);

    // The one century year that can fall inside a 32-year window sits this many
    // years ahead; it drops the leap day unless it is a multiple of 400.
    assign cen_off  = (r_m100 == '0) ? '0 : MOD100_W'(CENTURY) - r_m100;
    assign cen_sum  = {1'b0, r_m400} + {3'b0, cen_off};
    assign cen_mod  = (cen_sum >= (MOD400_W+1)'(QUAD_CENTURY))
                    ? cen_sum - (MOD400_W+1)'(QUAD_CENTURY) : cen_sum;
    assign cen_skip = (cen_mod != '0);
    assign len32 = YLEN_W'(COARSE_DAYS)
                 - {{(YLEN_W-1){1'b0}}, (cen_off < MOD100_W'(COARSE_YEARS)) && cen_skip};
    assign len4  = YLEN_W'(MID_DAYS)
                 - {{(YLEN_W-1){1'b0}}, (cen_off < MOD100_W'(MID_YEARS)) && cen_skip};

    assign mdays = f_month_days(r_month, leap);

    assign day_ext = {{(32-DAY_NUM_W){1'b0}}, i_day_number};
    assign is_zero = (i_day_number == '0);
    assign is_high = (day_ext >= SPAN_V);

    assign o_status.in_range   = !is_zero && !is_high;
    assign o_status.fits32     = (r_rem >= {{(DAY_NUM_W-YLEN_W){1'b0}}, len32});
    assign o_status.fits4      = (r_rem >= {{(DAY_NUM_W-YLEN_W){1'b0}}, len4});
    assign o_status.fits1      = (r_rem >= {{(DAY_NUM_W-YLEN_W){1'b0}}, len1});
    assign o_status.fits_month = (r_month != MONTH_DEC)
                               && (r_rem >= {{(DAY_NUM_W-DAY_W){1'b0}}, mdays});

    always_comb begin
        if (i_cmd.step32) begin
            step_years = STEP_W'(COARSE_YEARS);
            step_len   = len32;
        end else if (i_cmd.step4) begin
            step_years = STEP_W'(MID_YEARS);
            step_len   = len4;
        end else begin
            step_years = STEP_W'(1);
            step_len   = len1;
        end
    end

    assign m100_sum = {1'b0, r_m100} + {{(MOD100_W+1-STEP_W){1'b0}}, step_years};
    assign m400_sum = {1'b0, r_m400} + {{(MOD400_W+1-STEP_W){1'b0}}, step_years};

    always_comb begin
        n_rem   = r_rem;
        n_year  = r_year;
        n_month = r_month;
        n_m100  = r_m100;
        n_m400  = r_m400;
        n_clamp = r_clamp;
        if (i_cmd.load) begin
            n_m100  = M100_INIT;
            n_m400  = M400_INIT;
            n_clamp = 1'b0;
            if (is_zero) begin
                n_year  = FIRST_V;
                n_month = MONTH_JAN;
                n_rem   = '0;
                n_clamp = 1'b1;
            end else if (is_high) begin
                n_year  = LAST_V;
                n_month = MONTH_DEC;
                n_rem   = DAY_NUM_W'(DAY_DEC_LAST - DAY_FIRST);
                n_clamp = (day_ext != SPAN_V);
            end else begin
                n_year  = FIRST_V;
                n_month = MONTH_JAN;
                n_rem   = i_day_number - DAY_NUM_W'(1);
            end
        end else if (i_cmd.step32 || i_cmd.step4 || i_cmd.step1) begin
            n_rem  = r_rem - {{(DAY_NUM_W-YLEN_W){1'b0}}, step_len};
            n_year = YW'({{STEP_W{1'b0}}, r_year} + {{YW{1'b0}}, step_years});
            n_m100 = (m100_sum >= (MOD100_W+1)'(CENTURY))
                   ? MOD100_W'(m100_sum - (MOD100_W+1)'(CENTURY)) : MOD100_W'(m100_sum);
            n_m400 = (m400_sum >= (MOD400_W+1)'(QUAD_CENTURY))
                   ? MOD400_W'(m400_sum - (MOD400_W+1)'(QUAD_CENTURY)) : MOD400_W'(m400_sum);
        end else if (i_cmd.step_month) begin
            n_rem   = r_rem - {{(DAY_NUM_W-DAY_W){1'b0}}, mdays};
            n_month = r_month + MONTH_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_year  <= n_year;
        r_month <= n_month;
        r_m100  <= n_m100;
        r_m400  <= n_m400;
        r_clamp <= n_clamp;
        if (i_cmd.out_load) begin
            r_out_year  <= YEAR_OUT_W'(r_year);
            r_out_month <= r_month;
            r_out_day   <= r_rem[DAY_W-1:0] + DAY_FIRST;
            r_out_clamp <= r_clamp;
        end
    end

    assign o_year_out  = r_out_year;
    assign o_month_out = r_out_month;
    assign o_day_out   = r_out_day;
    assign o_clamped   = r_out_clamp;

endmodule

@@ src/day_number_to_date.sv @@
// Top level of the Gregorian day number to calendar date converter.
// Depends on dnd_pkg, dnd_ctrl, dnd_datapath and day_number_to_date_macros.svh.
//
// Usage: present a serial day number (1 is January 1 of FIRST_YEAR) on the
// input channel; one beat is taken when i_in_valid and o_in_ready are high.
// Each input beat yields exactly one output beat carrying year, month, day and
// a clamp flag, taken when o_out_valid and i_out_ready are high. Numbers below
// the first day give January 1 of FIRST_YEAR, numbers beyond the last day give
// December 31 of LAST_YEAR, and both raise o_clamped.
// The year walk steps 32 years, then 4, then 1 per cycle, and the month walk
// one month per cycle; each phase ends with a check that takes no step.
// An in-range result goes through both walks; a clamped result skips them.
// o_in_ready returns in the cycle after the result is loaded.
// One item is worked on at a time; o_in_ready is high only while idle.
// The output register decouples the sides: a new item is accepted and walked
// while the previous result waits; the next result is held until it is taken.
// Reset (i_rst_n low at a rising edge) empties the block: no result is valid.
`include "day_number_to_date_macros.svh"

module day_number_to_date
    import dnd_pkg::*;
#(
    parameter int FIRST_YEAR = 1900,
    parameter int LAST_YEAR  = 2099
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [DAY_NUM_W-1:0]  i_day_number,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [YEAR_OUT_W-1:0] o_year_out,
    output logic [MONTH_W-1:0]    o_month_out,
    output logic [DAY_W-1:0]      o_day_out,
    output logic                  o_clamped
);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_date_legal;
    logic    w_clamp_date;

    dnd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    dnd_datapath #(
        .FIRST_YEAR (FIRST_YEAR),
        .LAST_YEAR  (LAST_YEAR)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_day_number (i_day_number),
        .o_year_out   (o_year_out),
        .o_month_out  (o_month_out),
        .o_day_out    (o_day_out),
        .o_clamped    (o_clamped)
    );

    assign w_date_legal = (o_month_out != '0) && (o_month_out <= MONTH_DEC)
                       && (o_day_out != '0);
    assign w_clamp_date = ((o_month_out == MONTH_JAN) && (o_day_out == DAY_FIRST))
                       || ((o_month_out == MONTH_DEC) && (o_day_out == DAY_DEC_LAST));

    `DND_ASSERT_NOW(a_date_legal, o_out_valid, w_date_legal)
    `DND_ASSERT_NOW(a_clamp_edge, o_out_valid && o_clamped, w_clamp_date)
    `DND_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)

endmodule

@@ tb/day_number_to_date_tb.sv @@
// Self-checking testbench for day_number_to_date: serial day numbers to calendar dates.
// Depends on dnd_pkg and the day_number_to_date RTL; the expected dates come from a
// behavioral calendar walk inside this file.
module day_number_to_date_tb;
    import dnd_pkg::*;

    localparam int unsigned FIRST_YEAR    = 1900;
    localparam int unsigned LAST_YEAR     = 2099;
    localparam int unsigned MAX_DAY_NUM   = (1 << DAY_NUM_W) - 1;
    localparam int          IDLE_PERCENT  = 32;
    localparam int          SETTLE_CYCLES = 60;

    typedef struct packed {
        logic [YEAR_OUT_W-1:0] year;
        logic [MONTH_W-1:0]    month;
        logic [DAY_W-1:0]      day;
        logic                  clamped;
    } t_date;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_in_valid   = 1'b0;
    logic [DAY_NUM_W-1:0]  i_day_number = '0;
    logic                  i_out_ready  = 1'b0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [YEAR_OUT_W-1:0] o_year_out;
    logic [MONTH_W-1:0]    o_month_out;
    logic [DAY_W-1:0]      o_day_out;
    logic                  o_clamped;

    t_date       pending_dates[$];
    int unsigned span_days;
    bit          idle_enable   = 1'b1;
    int          hold_request  = 0;
    int          mismatch_count = 0;
    int          dates_checked = 0;
    int          clamped_seen  = 0;
    int          days_sent     = 0;

    day_number_to_date #(
        .FIRST_YEAR(FIRST_YEAR),
        .LAST_YEAR (LAST_YEAR)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_day_number(i_day_number),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_year_out  (o_year_out),
        .o_month_out (o_month_out),
        .o_day_out   (o_day_out),
        .o_clamped   (o_clamped)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit leap_year(input int unsigned yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    function automatic int unsigned days_in_year(input int unsigned yr);
        return leap_year(yr) ? 366 : 365;
    endfunction

    function automatic int unsigned days_in_month(input int unsigned mo, input int unsigned yr);
        case (mo)
            2:          return leap_year(yr) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:    return 31;
        endcase
    endfunction

    // Day number of January 1 of the given year.
    function automatic int unsigned new_year_day(input int unsigned yr);
        int unsigned n;
        n = 1;
        for (int unsigned y = FIRST_YEAR; y < yr; y++)
            n += days_in_year(y);
        return n;
    endfunction

    function automatic t_date calendar_date(input logic [DAY_NUM_W-1:0] n);
        t_date       d;
        int unsigned rem;
        int unsigned yr;
        int unsigned mo;
        if (n == 0) begin
            d.year    = YEAR_OUT_W'(FIRST_YEAR);
            d.month   = MONTH_W'(1);
            d.day     = DAY_W'(1);
            d.clamped = 1'b1;
        end else if (n >= span_days) begin
            d.year    = YEAR_OUT_W'(LAST_YEAR);
            d.month   = MONTH_W'(12);
            d.day     = DAY_W'(31);
            d.clamped = (n > span_days);
        end else begin
            rem = n - 1;
            yr  = FIRST_YEAR;
            while (rem >= days_in_year(yr)) begin
                rem -= days_in_year(yr);
                yr++;
            end
            mo = 1;
            while (mo < 12 && rem >= days_in_month(mo, yr)) begin
                rem -= days_in_month(mo, yr);
                mo++;
            end
            d.year    = YEAR_OUT_W'(yr);
            d.month   = MONTH_W'(mo);
            d.day     = DAY_W'(rem + 1);
            d.clamped = 1'b0;
        end
        return d;
    endfunction

    // Offers one day number and returns at the edge where the beat is taken.
    // Valid is only dropped during an idle gap, so it never sees two updates in one step.
    task automatic send_day(input int unsigned n);
        int gap;
        if (idle_enable && $urandom_range(99) < IDLE_PERCENT) begin
            gap = $urandom_range(1, 3);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_day_number <= DAY_NUM_W'(n);
        do @(posedge i_clk); while (!o_in_ready);
        pending_dates.push_back(calendar_date(DAY_NUM_W'(n)));
        days_sent++;
    endtask

    task automatic stop_and_drain();
        i_in_valid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_span_edges();
        int unsigned y2000;
        y2000 = new_year_day(2000);
        send_day(0);
        send_day(1);
        send_day(2);
        send_day(59);             // February 28 of a century year that is not leap
        send_day(60);             // March 1 right after it
        send_day(365);            // last day of the first year
        send_day(366);
        send_day(y2000 + 58);
        send_day(y2000 + 59);     // February 29 of a 400-year leap year
        send_day(y2000 + 60);
        send_day(y2000 + 365);    // December 31 of a leap year
        send_day(65536);
        send_day(span_days - 1);
        send_day(span_days);
        send_day(span_days + 1);
        send_day(MAX_DAY_NUM);
        send_day(MAX_DAY_NUM - 1);
        stop_and_drain();
    endtask

    task automatic test_random_in_span(input int count);
        repeat (count) send_day($urandom_range(1, span_days));
    endtask

    // Days where the year or month walk turns over.
    task automatic test_calendar_turns(input int count);
        int unsigned yr;
        int unsigned base;
        int unsigned mo;
        int unsigned off;
        repeat (count) begin
            yr   = $urandom_range(FIRST_YEAR, LAST_YEAR);
            base = new_year_day(yr);
            case ($urandom_range(3))
                0: send_day(base);
                1: send_day(base + days_in_year(yr) - 1);
                2: send_day(base + 58 + $urandom_range(1));
                default: begin
                    off = 0;
                    mo  = $urandom_range(1, 12);
                    for (int unsigned m = 1; m < mo; m++)
                        off += days_in_month(m, yr);
                    send_day(base + off + days_in_month(mo, yr) - $urandom_range(1));
                end
            endcase
        end
    endtask

    task automatic test_out_of_span(input int count);
        repeat (count) begin
            if ($urandom_range(3) == 0)
                send_day($urandom_range(0, MAX_DAY_NUM));
            else
                send_day($urandom_range(span_days + 1, MAX_DAY_NUM));
        end
        stop_and_drain();
    endtask

    task automatic test_back_to_back(input int count);
        idle_enable = 1'b0;
        repeat (count) send_day($urandom_range(1, span_days));
        stop_and_drain();
        idle_enable = 1'b1;
    endtask

    // The receiver stalls long enough that the block fills and holds off the sender.
    task automatic test_output_stall(input int count);
        hold_request = 400;
        repeat (count) send_day($urandom_range(0, MAX_DAY_NUM));
        stop_and_drain();
    endtask

    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else if (idle_enable && $urandom_range(99) < IDLE_PERCENT) begin
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : date_checker
        t_date want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (pending_dates.size() == 0) begin
                    $display("%0t: unexpected beat %0d-%0d-%0d clamped %0b", $time,
                             o_year_out, o_month_out, o_day_out, o_clamped);
                    mismatch_count++;
                end else begin
                    want = pending_dates.pop_front();
                    dates_checked++;
                    if (o_clamped)
                        clamped_seen++;
                    if (o_year_out !== want.year) begin
                        $display("%0t: year expected %0d actual %0d", $time, want.year,
                                 o_year_out);
                        mismatch_count++;
                    end
                    if (o_month_out !== want.month) begin
                        $display("%0t: month expected %0d actual %0d", $time, want.month,
                                 o_month_out);
                        mismatch_count++;
                    end
                    if (o_day_out !== want.day) begin
                        $display("%0t: day expected %0d actual %0d", $time, want.day,
                                 o_day_out);
                        mismatch_count++;
                    end
                    if (o_clamped !== want.clamped) begin
                        $display("%0t: clamped expected %0b actual %0b", $time,
                                 want.clamped, o_clamped);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial begin : watchdog
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        span_days = 0;
        for (int unsigned y = FIRST_YEAR; y <= LAST_YEAR; y++)
            span_days += days_in_year(y);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_span_edges();
        test_random_in_span(600);
        test_calendar_turns(300);
        test_out_of_span(150);
        test_back_to_back(150);
        test_output_stall(30);
        test_random_in_span(500);
        stop_and_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Converted %0d day numbers, %0d dates checked, %0d of them saturated.",
                 days_sent, dates_checked, clamped_seen);
        $display("Covered span edges, leap and century years, month ends and output stalls.");
        if (mismatch_count == 0 && pending_dates.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
